FILE: hw/rtl/jtc_pkg.sv
// Shared types, constants and helper functions for the JSON token classifier.
// No dependencies; imported by every module of the block.
package jtc_pkg;

  localparam int unsigned MAX_TOKEN_LEN = 65535;
  localparam int unsigned POS_W         = $clog2(MAX_TOKEN_LEN + 2);
  localparam int unsigned FIFO_DEPTH    = 2;
  localparam int unsigned PTR_W         = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W         = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] INT_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    CLS_OPERATOR = 3'd0,
    CLS_BOOLEAN  = 3'd1,
    CLS_INTEGER  = 3'd2,
    CLS_FLOAT    = 3'd3,
    CLS_STRING   = 3'd4,
    CLS_INVALID  = 3'd5
  } token_class_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [7:0]       first;
    logic [7:0]       prev;
    logic [1:0]       minus_cnt;
    logic [1:0]       dot_cnt;
    logic [1:0]       dot_pos;
    logic [1:0]       bad;
    logic [1:0]       lit;
    logic             quote;
    logic [63:0]      acc;
  } tok_t;

  localparam tok_t TOK_CLEAR = '{
    pos: '0, first: '0, prev: '0, minus_cnt: '0, dot_cnt: '0,
    dot_pos: '0, bad: '0, lit: 2'b11, quote: 1'b0, acc: '0
  };

  typedef struct packed {
    tok_t       tok;
    logic [7:0] c;
  } snap_t;

  typedef struct packed {
    logic signed [63:0] int_value;
    logic [7:0]         operator_code;
    logic               bool_value;
    token_class_t       token_class;
  } res_t;

  function automatic logic [7:0] true_char(input logic [1:0] i);
    logic [7:0] ch;
    case (i)
      2'd0:    ch = 8'h74;
      2'd1:    ch = 8'h72;
      2'd2:    ch = 8'h75;
      default: ch = 8'h65;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] false_char(input logic [2:0] i);
    logic [7:0] ch;
    case (i)
      3'd0:    ch = 8'h66;
      3'd1:    ch = 8'h61;
      3'd2:    ch = 8'h6C;
      3'd3:    ch = 8'h73;
      default: ch = 8'h65;
    endcase
    return ch;
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return c inside {CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COLON, CH_COMMA};
  endfunction

endpackage

FILE: hw/rtl/jtc_front.sv
// Front end: per-byte token state update, end-of-token snapshot and classification.
// Depends on jtc_pkg.
module jtc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_data,
  input  logic          in_last,
  output logic          in_ready,
  output logic          res_valid,
  output jtc_pkg::res_t res,
  input  logic          res_ready
);
  import jtc_pkg::*;

  tok_t        tok_r, tok_nxt;
  snap_t       snap_r, snap_nxt;
  logic        snap_v_r, snap_v_nxt;
  logic        accept;
  logic [7:0]  c;
  logic [3:0]  d;
  logic [67:0] prod;
  logic        is_digit;
  logic        signed_ok;

  assign c        = in_data;
  assign in_ready = !snap_v_r || res_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    tok_nxt  = tok_r;
    d        = 4'(c - CH_ZERO);
    prod     = {1'b0, tok_r.acc, 3'b000} + {3'b000, tok_r.acc, 1'b0} + {64'd0, d};
    is_digit = c inside {[CH_ZERO:CH_NINE]};
    if (tok_r.pos == '0) begin
      tok_nxt.first = c;
    end
    if (c == CH_MINUS) begin
      if (tok_r.minus_cnt != 2'd2) tok_nxt.minus_cnt = tok_r.minus_cnt + 2'd1;
    end else if (c == CH_DOT) begin
      if (tok_r.dot_cnt != 2'd2) tok_nxt.dot_cnt = tok_r.dot_cnt + 2'd1;
      tok_nxt.dot_pos = (tok_r.pos >= POS_W'(2)) ? 2'd2 : tok_r.pos[1:0];
      tok_nxt.bad[0]  = 1'b1;
    end else if (is_digit) begin
      tok_nxt.acc = (prod > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : prod[63:0];
    end else begin
      tok_nxt.bad = 2'b11;
    end
    if (!(tok_r.pos < POS_W'(4) && c == true_char(tok_r.pos[1:0]))) begin
      tok_nxt.lit[0] = 1'b0;
    end
    if (!(tok_r.pos < POS_W'(5) && c == false_char(tok_r.pos[2:0]))) begin
      tok_nxt.lit[1] = 1'b0;
    end
    if (!in_last && tok_r.pos != '0 && c == CH_QUOTE && tok_r.prev != CH_BSLASH) begin
      tok_nxt.quote = 1'b1;
    end
    tok_nxt.prev = c;
    if (tok_r.pos <= POS_W'(MAX_TOKEN_LEN)) tok_nxt.pos = tok_r.pos + POS_W'(1);
    snap_nxt.tok = tok_nxt;
    snap_nxt.c   = c;
    if (accept && in_last) snap_v_nxt = 1'b1;
    else if (res_ready)    snap_v_nxt = 1'b0;
    else                   snap_v_nxt = snap_v_r;
  end

  always_comb begin
    res           = '{int_value: '0, operator_code: '0, bool_value: 1'b0,
                      token_class: CLS_INVALID};
    signed_ok     = snap_r.tok.minus_cnt == 2'd1 && snap_r.tok.first == CH_MINUS;
    if (snap_r.tok.pos > POS_W'(MAX_TOKEN_LEN)) begin
      res.token_class = CLS_INVALID;
    end else if (snap_r.tok.pos == POS_W'(1) && is_operator(snap_r.c)) begin
      res.token_class   = CLS_OPERATOR;
      res.operator_code = snap_r.c;
    end else if (snap_r.tok.lit[0] && snap_r.tok.pos == POS_W'(4)) begin
      res.token_class = CLS_BOOLEAN;
      res.bool_value  = 1'b1;
    end else if (snap_r.tok.lit[1] && snap_r.tok.pos == POS_W'(5)) begin
      res.token_class = CLS_BOOLEAN;
    end else if (!snap_r.tok.bad[0] && (snap_r.tok.minus_cnt == 2'd0 || signed_ok)) begin
      res.token_class = CLS_INTEGER;
      if (snap_r.tok.minus_cnt == 2'd1) begin
        res.int_value = 64'd0 - snap_r.tok.acc;
      end else begin
        res.int_value = snap_r.tok.acc[63] ? INT_MAX : snap_r.tok.acc;
      end
    end else if (!snap_r.tok.bad[1] && snap_r.tok.dot_cnt == 2'd1 &&
                 ((snap_r.tok.minus_cnt == 2'd0 && snap_r.tok.dot_pos >= 2'd1) ||
                  (signed_ok && snap_r.tok.dot_pos == 2'd2))) begin
      res.token_class = CLS_FLOAT;
    end else if (snap_r.tok.first == CH_QUOTE && snap_r.c == CH_QUOTE &&
                 snap_r.tok.pos > POS_W'(1) && !snap_r.tok.quote) begin
      res.token_class = CLS_STRING;
    end
  end

  assign res_valid = snap_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r    <= TOK_CLEAR;
      snap_v_r <= 1'b0;
    end else begin
      snap_v_r <= snap_v_nxt;
      if (accept) begin
        tok_r <= in_last ? TOK_CLEAR : tok_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last) snap_r <= snap_nxt;
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> tok_r.pos == '0 && tok_r.acc == '0 && snap_v_r)
    else $error("token state not cleared after last byte");

  a_snap_held: assert property (@(posedge clk) disable iff (!rst_n)
    snap_v_r && !res_ready |=> snap_v_r && $stable(snap_r))
    else $error("pending result lost while stalled");

  a_acc_limit: assert property (@(posedge clk) disable iff (!rst_n)
    tok_r.acc <= MAG_LIMIT)
    else $error("accumulator above saturation limit");

endmodule

FILE: hw/rtl/jtc_fifo.sv
// Short result queue between the classifying front end and the output stage.
// Depends on jtc_pkg.
module jtc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  jtc_pkg::res_t push_data,
  output logic          push_ready,
  output logic          pop_valid,
  output jtc_pkg::res_t pop_data,
  input  logic          pop_ready
);
  import jtc_pkg::*;

  res_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = cnt_r != CNT_W'(FIFO_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + CNT_W'(1);
    else if (!push && pop) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("queue count out of range");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("queue count did not advance on push");

  a_cnt_drop: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("queue count did not drop on pop");

endmodule

FILE: hw/rtl/jtc_back.sv
// Back end: output register that drains the result queue onto the master stream.
// Depends on jtc_pkg.
module jtc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  jtc_pkg::res_t q_data,
  output logic          q_ready,
  output logic          out_valid,
  output jtc_pkg::res_t out_data,
  input  logic          out_ready
);
  import jtc_pkg::*;

  logic out_v_r;
  res_t out_d_r;

  assign q_ready   = !out_v_r || out_ready;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (q_ready) begin
      out_v_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) out_d_r <= q_data;
  end

endmodule

FILE: hw/rtl/json_token_classifier_top.sv
// JSON token classifier top level: stream ports around front end, queue and output stage.
// Depends on jtc_pkg, jtc_front, jtc_fifo, jtc_back.
//
// Feed a pre-split token one byte per transaction on the slave stream, with
// in_tlast on its final byte. Each token yields exactly one result transaction
// (class, boolean value, operator byte, saturated 64-bit integer). The block
// accepts one byte every cycle, tokens back to back, unless the result path
// stalls; the cycle is set by the per-byte multiply-by-ten accumulate, a 68-bit
// add and saturation compare. A result passes through the end-of-token snapshot,
// the two-entry result queue and the output register to the master stream. When
// the master side stalls, up to four results are held before in_tready drops.
// Tokens longer than 65535 bytes are reported invalid.
module json_token_classifier_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // [2:0] token_class, [3] bool_value,
                                  // [11:4] operator_code, [75:12] int_value
);
  import jtc_pkg::*;

  logic f_valid, f_ready, q_valid, q_ready;
  res_t f_res, q_res, o_res;

  jtc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .res_valid (f_valid),
    .res       (f_res),
    .res_ready (f_ready)
  );

  jtc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_data  (f_res),
    .push_ready (f_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_res),
    .pop_ready  (q_ready)
  );

  jtc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_res),
    .q_ready   (q_ready),
    .out_valid (out_tvalid),
    .out_data  (o_res),
    .out_ready (out_tready)
  );

  assign out_tdata = {4'b0000, o_res.int_value, o_res.operator_code,
                      o_res.bool_value, o_res.token_class};

endmodule

FILE: dv/json_token_classifier_top_test.sv
// Self-checking testbench for json_token_classifier_top: streams tokens byte by byte,
// predicts each token's class and value, and checks every result transaction in order.
// Depends on jtc_pkg and the json_token_classifier_top RTL.
module json_token_classifier_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jtc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_BYTES = 1200;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES  = 300;

  localparam logic [0:5][7:0] OP_BYTES = {CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                                          CH_COLON, CH_COMMA};
  localparam logic [0:11][7:0] NUM_CHARS  = "0123456789-.";
  localparam logic [0:3][7:0]  TRUE_WORD  = "true";
  localparam logic [0:4][7:0]  FALSE_WORD = "false";

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] char_byte
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // [2:0] token_class, [3] bool_value,
                           // [11:4] operator_code, [75:12] int_value

  res_t        expected_results[$];
  logic [7:0]  token_buf[$];
  int unsigned errors;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned hold_off;
  bit          steady_flow;

  // token state of the predictor
  int unsigned tok_len;
  logic [7:0]  tok_first;
  logic [7:0]  tok_prev;
  logic [1:0]  minus_seen;
  logic [1:0]  dots_seen;
  int unsigned last_dot;
  logic        not_int;
  logic        not_num;
  logic        maybe_true;
  logic        maybe_false;
  logic        stray_quote;
  logic [63:0] magnitude;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  json_token_classifier_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic void clear_token_state();
    tok_len     = 0;
    tok_first   = 8'h00;
    tok_prev    = 8'h00;
    minus_seen  = 2'd0;
    dots_seen   = 2'd0;
    last_dot    = 0;
    not_int     = 1'b0;
    not_num     = 1'b0;
    maybe_true  = 1'b1;
    maybe_false = 1'b1;
    stray_quote = 1'b0;
    magnitude   = 64'd0;
  endfunction

  function automatic void take_byte(input logic [7:0] c, input logic last);
    int unsigned idx;
    logic [63:0] digit;
    logic        op_hit;
    res_t        r;
    idx = tok_len;
    if (idx == 0) tok_first = c;
    if (c == CH_MINUS) begin
      if (minus_seen < 2'd2) minus_seen = minus_seen + 2'd1;
    end else if (c == CH_DOT) begin
      if (dots_seen < 2'd2) dots_seen = dots_seen + 2'd1;
      last_dot = idx;
      not_int  = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      digit = 64'(c - CH_ZERO);
      if (magnitude > (MAG_LIMIT - digit) / 10) magnitude = MAG_LIMIT;
      else magnitude = magnitude * 10 + digit;
    end else begin
      not_int = 1'b1;
      not_num = 1'b1;
    end
    if (idx >= 4 || c != TRUE_WORD[idx[1:0]]) maybe_true = 1'b0;
    if (idx >= 5 || c != FALSE_WORD[idx[2:0]]) maybe_false = 1'b0;
    if (!last && idx >= 1 && c == CH_QUOTE && tok_prev != CH_BSLASH) stray_quote = 1'b1;
    tok_prev = c;
    if (tok_len <= MAX_TOKEN_LEN) tok_len++;
    if (!last) return;

    op_hit = 1'b0;
    for (int k = 0; k < 6; k++) if (c == OP_BYTES[k]) op_hit = 1'b1;
    r.token_class   = CLS_INVALID;
    r.bool_value    = 1'b0;
    r.operator_code = 8'h00;
    r.int_value     = 64'sd0;
    if (tok_len <= MAX_TOKEN_LEN) begin
      if (tok_len == 1 && op_hit) begin
        r.token_class   = CLS_OPERATOR;
        r.operator_code = c;
      end else if (maybe_true && tok_len == 4) begin
        r.token_class = CLS_BOOLEAN;
        r.bool_value  = 1'b1;
      end else if (maybe_false && tok_len == 5) begin
        r.token_class = CLS_BOOLEAN;
      end else if (!not_int &&
                   (minus_seen == 2'd0 || (minus_seen == 2'd1 && tok_first == CH_MINUS))) begin
        r.token_class = CLS_INTEGER;
        if (minus_seen == 2'd1) r.int_value = 64'd0 - magnitude;
        else r.int_value = (magnitude >= MAG_LIMIT) ? INT_MAX : magnitude;
      end else if (!not_num && dots_seen == 2'd1 &&
                   ((minus_seen == 2'd0 && last_dot >= 1) ||
                    (minus_seen == 2'd1 && tok_first == CH_MINUS && last_dot >= 2))) begin
        r.token_class = CLS_FLOAT;
      end else if (tok_first == CH_QUOTE && c == CH_QUOTE && tok_len > 1 && !stray_quote) begin
        r.token_class = CLS_STRING;
      end
    end
    expected_results.push_back(r);
    clear_token_state();
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last);
    while (!steady_flow && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    take_byte(c, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_token();
    for (int i = 0; i < token_buf.size(); i++) send_byte(token_buf[i], i == token_buf.size() - 1);
    token_buf.delete();
  endtask

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) token_buf.push_back(s[i]);
  endfunction

  task automatic send_text(input string s);
    put_text(s);
    send_token();
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  function automatic void build_random_token();
    int unsigned kind;
    int unsigned pick;
    bit          all_nines;
    kind = $urandom_range(99);
    if (kind < 10) begin
      token_buf.push_back(OP_BYTES[$urandom_range(5)]);
    end else if (kind < 20) begin
      if ($urandom_range(1) != 0) put_text("true");
      else put_text("false");
    end else if (kind < 40) begin
      if ($urandom_range(3) == 0) token_buf.push_back(CH_MINUS);
      all_nines = ($urandom_range(9) == 0);
      repeat ($urandom_range(1, 22))
        token_buf.push_back(all_nines ? CH_NINE : 8'(CH_ZERO + $urandom_range(9)));
    end else if (kind < 55) begin
      if ($urandom_range(2) == 0) token_buf.push_back(CH_MINUS);
      repeat ($urandom_range(0, 5)) token_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
      token_buf.push_back(CH_DOT);
      repeat ($urandom_range(0, 5)) token_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
    end else if (kind < 75) begin
      token_buf.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 10)) begin
        pick = $urandom_range(19);
        if (pick == 0) begin
          token_buf.push_back(CH_BSLASH);
          token_buf.push_back(CH_QUOTE);
        end else if (pick == 1) begin
          token_buf.push_back(CH_QUOTE);
        end else if (pick == 2) begin
          token_buf.push_back(CH_BSLASH);
        end else begin
          token_buf.push_back(8'($urandom_range(32, 126)));
        end
      end
      token_buf.push_back(CH_QUOTE);
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 8)) token_buf.push_back(NUM_CHARS[$urandom_range(11)]);
    end else begin
      repeat ($urandom_range(1, 12)) token_buf.push_back(8'($urandom_range(255)));
    end
    if (kind >= 10 && kind < 75 && $urandom_range(9) == 0)
      token_buf[$urandom_range(token_buf.size() - 1)] = 8'($urandom_range(255));
  endfunction

  task automatic test_operators();
    for (int k = 0; k < 6; k++) send_byte(OP_BYTES[k], 1'b1);
    send_text("{}");
    send_text(":,");
    drain();
  endtask

  task automatic test_literals();
    send_text("true");
    send_text("false");
    send_text("tru");
    send_text("truex");
    send_text("fals");
    send_text("TRUE");
    drain();
  endtask

  task automatic test_integers();
    send_text("0");
    send_text("-");
    send_text("-0");
    send_text("9223372036854775807");
    send_text("9223372036854775808");
    send_text("-9223372036854775808");
    send_text("-99999999999999999999");
    send_text("1-2");
    send_text("--1");
    drain();
  endtask

  task automatic test_floats();
    send_text("1.5");
    send_text("-1.5");
    send_text(".5");
    send_text("-.5");
    send_text("5.");
    send_text("1..2");
    send_text("1.5e3");
    send_text("12345.678");
    drain();
  endtask

  task automatic test_strings();
    send_text("\"\"");
    send_text("\"abc\"");
    send_text("\"a\\\"b\"");
    send_text("\"a\"b\"");
    send_text("\"");
    send_text("\"abc");
    drain();
  endtask

  task automatic test_odd_bytes();
    token_buf.push_back(8'h00);
    send_token();
    token_buf.push_back(CH_ZERO);
    token_buf.push_back(8'h00);
    send_token();
    token_buf.push_back(CH_QUOTE);
    token_buf.push_back(8'h00);
    token_buf.push_back(CH_QUOTE);
    send_token();
    token_buf.push_back(8'hFF);
    send_token();
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = HOLD_CYCLES;
    repeat (40) send_byte(OP_BYTES[$urandom_range(5)], 1'b1);
    repeat (10) begin
      build_random_token();
      send_token();
    end
    drain();
  endtask

  task automatic test_back_to_back();
    steady_flow = 1'b1;
    repeat (60) begin
      build_random_token();
      send_token();
    end
    steady_flow = 1'b0;
    drain();
  endtask

  task automatic test_random_tokens();
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      build_random_token();
      send_token();
    end
    drain();
  endtask

  always @(negedge clk) begin
    if (hold_off != 0) begin
      out_tready <= 1'b0;
      hold_off--;
    end else begin
      out_tready <= steady_flow || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no token pending: expected none, actual %h",
                 $time, out_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[2:0] !== want.token_class) begin
          $display("%0t: token_class expected %0d actual %0d",
                   $time, want.token_class, out_tdata[2:0]);
          errors++;
        end
        if (out_tdata[3] !== want.bool_value) begin
          $display("%0t: bool_value expected %0d actual %0d",
                   $time, want.bool_value, out_tdata[3]);
          errors++;
        end
        if (out_tdata[11:4] !== want.operator_code) begin
          $display("%0t: operator_code expected %h actual %h",
                   $time, want.operator_code, out_tdata[11:4]);
          errors++;
        end
        if (out_tdata[75:12] !== want.int_value) begin
          $display("%0t: int_value expected %0d actual %0d",
                   $time, want.int_value, $signed(out_tdata[75:12]));
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    errors      = 0;
    cycle_count = 0;
    bytes_sent  = 0;
    hold_off    = 0;
    steady_flow = 1'b0;
    clear_token_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_operators();
    test_literals();
    test_integers();
    test_floats();
    test_strings();
    test_odd_bytes();
    test_backpressure();
    test_back_to_back();
    test_random_tokens();

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/jtc_pkg.sv
hw/rtl/jtc_front.sv
hw/rtl/jtc_fifo.sv
hw/rtl/jtc_back.sv
hw/rtl/json_token_classifier_top.sv
dv/json_token_classifier_top_test.sv
